/* rtl/rhc_pkg.sv */
// Shared constants and the stage word type of the RGB to HSV converter.
package rhc_pkg;

    localparam int unsigned NUM_CELLS  = 8;
    localparam int unsigned NUM_STAGES = NUM_CELLS + 2;

    localparam logic [7:0] SAT_SCALE      = 8'd255;
    localparam logic [7:0] HUE_STEP       = 8'd43;
    localparam logic [7:0] HUE_BASE_RED   = 8'd0;
    localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
    localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;

    // Data carried from cell to cell along the divider chain.
    typedef struct packed {
        logic [7:0]  brightness;
        logic        zero_spread;
        logic        hue_neg;
        logic [7:0]  hue_base;
        logic [15:0] sat_rem;
        logic [7:0]  sat_div;
        logic [7:0]  sat_quot;
        logic [15:0] hue_rem;
        logic [7:0]  hue_div;
        logic [7:0]  hue_quot;
    } div_word_t;

endpackage

/* rtl/rgb_to_hsv_converter_core.sv */
// Top level of the pipelined 8-bit RGB to HSV converter.
//
// Usage:
//   Input channel s_valid/s_ready carries one RGB pixel per item on
//   s_red, s_green, s_blue. Result channel m_valid/m_ready carries one
//   HSV triple per item on m_hue, m_saturation, m_brightness, in input
//   order.
//   An accepted item passes one front stage (max/min, sector,
//   dividends), eight divider cells that each settle one quotient bit
//   for saturation and hue, and one output stage, to reach m_valid.
//   Throughput is one item per clock while the receiver does not stall;
//   the divider chain sets the latency, and every cell takes a new item each cycle.
//   Each stage holds its own valid bit and loads whenever it or any stage
//   after it is empty, so bubbles collapse while the receiver stalls and
//   s_ready stays high until all ten stages hold an item.
//   s_ready depends combinationally on m_ready.
//   Reset (aresetn low, synchronous) empties the pipeline; there is no
//   other state.
module rgb_to_hsv_converter_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_hue,
    output logic [7:0] m_saturation,
    output logic [7:0] m_brightness
);

    localparam int unsigned LAST = rhc_pkg::NUM_STAGES - 1;

    // stage_valid[0] is the front stage, [LAST] the output register
    logic [LAST:0]      stage_valid;
    logic [LAST:0]      stage_load;
    rhc_pkg::div_word_t stage_word [0:rhc_pkg::NUM_CELLS];

    // A stage may load when the sink takes the item or any later stage
    // (itself included) has a hole.
    genvar k;
    generate
        for (k = 0; k <= LAST; k++) begin : g_load
            assign stage_load[k] = m_ready || !(&stage_valid[LAST:k]);
        end
    endgenerate

    assign s_ready = stage_load[0];

    rhc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (stage_load[0]),
        .in_valid  (s_valid),
        .red       (s_red),
        .green     (s_green),
        .blue      (s_blue),
        .out_valid (stage_valid[0]),
        .out_word  (stage_word[0])
    );

    // Divider chain: each cell retires one quotient bit, MSB first.
    generate
        for (k = 1; k <= rhc_pkg::NUM_CELLS; k++) begin : g_cell
            rhc_div_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .load      (stage_load[k]),
                .in_valid  (stage_valid[k-1]),
                .in_word   (stage_word[k-1]),
                .out_valid (stage_valid[k]),
                .out_word  (stage_word[k])
            );
        end
    endgenerate

    rhc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (stage_load[LAST]),
        .in_valid   (stage_valid[LAST-1]),
        .in_word    (stage_word[rhc_pkg::NUM_CELLS]),
        .out_valid  (stage_valid[LAST]),
        .hue        (m_hue),
        .saturation (m_saturation),
        .brightness (m_brightness)
    );

    assign m_valid = stage_valid[LAST];

    // Grey and black pixels always come out with zero hue.
    a_grey_hue : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_saturation == 8'd0) |-> (m_hue == 8'd0))
        else $error("nonzero hue with zero saturation");

    // Black pixel gives zero saturation.
    a_black_sat : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_brightness == 8'd0) |-> (m_saturation == 8'd0))
        else $error("nonzero saturation with zero brightness");

    // Any hole in the pipeline must let a new item in.
    a_ready_on_hole : assert property (@(posedge aclk) disable iff (!aresetn)
        !(&stage_valid) |-> s_ready)
        else $error("input stalled while pipeline has a hole");

    // A stalled output item stays put until taken.
    a_out_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hue) && $stable(m_saturation))
        else $error("output item lost under stall");

endmodule

/* rtl/rhc_front.sv */
// Front stage: max/min, hue sector, and the two dividends, registered.
module rhc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic               in_valid,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    output logic               out_valid,
    output rhc_pkg::div_word_t out_word
);

    logic               valid_reg;
    rhc_pkg::div_word_t word_reg;
    rhc_pkg::div_word_t word_next;

    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  spread;
    logic [7:0]  op_a;
    logic [7:0]  op_b;
    logic [7:0]  mag;
    logic [7:0]  base;

    always_comb begin
        hi = red;
        if (green > hi) hi = green;
        if (blue > hi) hi = blue;
        lo = red;
        if (green < lo) lo = green;
        if (blue < lo) lo = blue;
        spread = hi - lo;

        // sector choice: red first, then green, on ties
        if (hi == red) begin
            op_a = green;
            op_b = blue;
            base = rhc_pkg::HUE_BASE_RED;
        end else if (hi == green) begin
            op_a = blue;
            op_b = red;
            base = rhc_pkg::HUE_BASE_GREEN;
        end else begin
            op_a = red;
            op_b = green;
            base = rhc_pkg::HUE_BASE_BLUE;
        end
        mag = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);

        word_next.brightness  = hi;
        word_next.zero_spread = (spread == 8'd0);
        word_next.hue_neg     = (op_a < op_b);
        word_next.hue_base    = base;
        // 255 * spread without a multiplier
        word_next.sat_rem     = {spread, 8'h00} - {8'h00, spread};
        word_next.sat_div     = hi;
        word_next.sat_quot    = 8'd0;
        word_next.hue_rem     = 16'(mag) * 16'(rhc_pkg::HUE_STEP);
        word_next.hue_div     = spread;
        word_next.hue_quot    = 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* rtl/rhc_div_cell.sv */
// Divider cell: one restoring quotient bit for both the saturation and hue quotients.
module rhc_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic               in_valid,
    input  rhc_pkg::div_word_t in_word,
    output logic               out_valid,
    output rhc_pkg::div_word_t out_word
);

    logic               valid_reg;
    rhc_pkg::div_word_t word_reg;
    rhc_pkg::div_word_t word_next;

    logic [15:0] sat_dshift;
    logic [15:0] hue_dshift;
    logic        sat_bit;
    logic        hue_bit;
    logic [15:0] sat_left;
    logic [15:0] hue_left;

    always_comb begin
        // remainder stays below divisor << 8, so the doubled remainder fits
        sat_dshift = {1'b0, in_word.sat_div, 7'd0};
        hue_dshift = {1'b0, in_word.hue_div, 7'd0};
        sat_bit    = (in_word.sat_rem >= sat_dshift);
        hue_bit    = (in_word.hue_rem >= hue_dshift);
        sat_left   = sat_bit ? (in_word.sat_rem - sat_dshift) : in_word.sat_rem;
        hue_left   = hue_bit ? (in_word.hue_rem - hue_dshift) : in_word.hue_rem;

        word_next          = in_word;
        word_next.sat_rem  = {sat_left[14:0], 1'b0};
        word_next.hue_rem  = {hue_left[14:0], 1'b0};
        word_next.sat_quot = {in_word.sat_quot[6:0], sat_bit};
        word_next.hue_quot = {in_word.hue_quot[6:0], hue_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* rtl/rhc_back.sv */
// Back stage: signs and offsets the hue, applies the grey and black cases, output register.
module rhc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic               in_valid,
    input  rhc_pkg::div_word_t in_word,
    output logic               out_valid,
    output logic [7:0]         hue,
    output logic [7:0]         saturation,
    output logic [7:0]         brightness
);

    logic       valid_reg;
    logic [7:0] hue_reg;
    logic [7:0] sat_reg;
    logic [7:0] bright_reg;
    logic [7:0] hue_next;
    logic [7:0] sat_next;

    always_comb begin
        // zero spread covers both grey and black pixels
        if (in_word.zero_spread) begin
            hue_next = 8'd0;
            sat_next = 8'd0;
        end else begin
            hue_next = in_word.hue_neg ? (in_word.hue_base - in_word.hue_quot)
                                       : (in_word.hue_base + in_word.hue_quot);
            sat_next = in_word.sat_quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= in_word.brightness;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the pipelined 8-bit RGB to HSV converter.
module tb_top;

    // ------------------------------------------------------------------
    // Run limits and predictor constants
    // ------------------------------------------------------------------
    localparam int CLK_HALF     = 10;      // 20 ns period
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1930;    // directed rows make up the rest
    localparam int DRAIN_AT     = 900;     // sender waits for an empty pipe here
    localparam int BURST_FIRST  = 1300;    // back-to-back window on the input
    localparam int BURST_LAST   = 1500;
    localparam int HOLD_AFTER   = 500;     // receiver's long hold-off starts here
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 20;
    localparam int CYCLE_LIMIT  = 500_000;

    localparam int SAT_FULL   = 255;
    localparam int HUE_STEP   = 43;
    localparam int BASE_RED   = 0;
    localparam int BASE_GREEN = 85;
    localparam int BASE_BLUE  = 171;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_t;

    // One directed row: the pixel, and a hand-typed result where `typed` is set.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       typed;
        hsv_t       hsv;
    } pixel_row_t;

    localparam int NUM_ROWS = 20;

    // ------------------------------------------------------------------
    // DUT signals; the driven inputs are known from time zero
    // ------------------------------------------------------------------
    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [7:0] s_red        = 8'd0;
    logic [7:0] s_green      = 8'd0;
    logic [7:0] s_blue       = 8'd0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [7:0] m_hue;
    logic [7:0] m_saturation;
    logic [7:0] m_brightness;

    hsv_t       hsv_due[$];        // results owed by the block, oldest first
    int         accepted_items = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    pixel_row_t directed_rows [0:NUM_ROWS-1];

    always #(CLK_HALF) aclk = ~aclk;

    rgb_to_hsv_converter_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_brightness (m_brightness)
    );

    // ------------------------------------------------------------------
    // Predictor: integer HSV of one pixel
    // ------------------------------------------------------------------
    function automatic hsv_t rgb_to_hsv(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        int   hi;
        int   lo;
        int   spread;
        int   sat;
        int   num;
        int   base;
        int   h;
        hsv_t px;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        px.brightness = hi[7:0];
        px.saturation = 8'd0;
        px.hue        = 8'd0;
        // black keeps hue and saturation at zero
        if (hi != 0) begin
            spread = hi - lo;
            sat    = (SAT_FULL * spread) / hi;
            px.saturation = sat[7:0];
            // grey (zero spread) keeps hue at zero
            if (sat != 0) begin
                // ties resolve red first, then green, then blue
                if (hi == r) begin
                    base = BASE_RED;
                    num  = int'(g) - int'(b);
                end else if (hi == g) begin
                    base = BASE_GREEN;
                    num  = int'(b) - int'(r);
                end else begin
                    base = BASE_BLUE;
                    num  = int'(r) - int'(g);
                end
                // signed int division truncates toward zero; the slice wraps mod 256
                h      = base + (HUE_STEP * num) / spread;
                px.hue = h[7:0];
            end
        end
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Directed rows: extremes, ties, wrap, plus a few checked by the predictor
    // ------------------------------------------------------------------
    initial begin
        directed_rows = '{
            '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},   // black
            '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}}, // white
            '{8'd128, 8'd128, 8'd128, 1'b1, '{8'd0,   8'd0,   8'd128}}, // mid grey
            '{8'd1,   8'd1,   8'd1,   1'b1, '{8'd0,   8'd0,   8'd1}},   // darkest grey
            '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd255}}, // pure red
            '{8'd0,   8'd255, 8'd0,   1'b1, '{8'd85,  8'd255, 8'd255}}, // pure green
            '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd171, 8'd255, 8'd255}}, // pure blue
            '{8'd255, 8'd255, 8'd0,   1'b1, '{8'd43,  8'd255, 8'd255}}, // red/green tie
            '{8'd0,   8'd255, 8'd255, 1'b1, '{8'd128, 8'd255, 8'd255}}, // green/blue tie
            '{8'd255, 8'd0,   8'd255, 1'b1, '{8'd213, 8'd255, 8'd255}}, // red/blue tie
            '{8'd255, 8'd0,   8'd6,   1'b1, '{8'd255, 8'd255, 8'd255}}, // hue -1 wraps
            '{8'd255, 8'd0,   8'd1,   1'b1, '{8'd0,   8'd255, 8'd255}}, // offset truncates to 0
            '{8'd1,   8'd0,   8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'd0,   8'd0,   8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'd200, 8'd100, 8'd50,  1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'd10,  8'd200, 8'd30,  1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'd3,   8'd7,   8'd250, 1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'd254, 8'd1,   8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'd255, 8'd254, 8'd253, 1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'd1,   8'd2,   8'd3,   1'b0, '{8'd0,   8'd0,   8'd0}}
        };
    end

    // ------------------------------------------------------------------
    // Gap lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)      return 0;
        else if (roll < 85) return $urandom_range(1, 3);
        else if (roll < 97) return $urandom_range(4, 10);
        else                return $urandom_range(20, 60);
    endfunction

    // Random pixel, biased toward greys, tied maxima and dark values
    task automatic draw_pixel(output logic [7:0] r, output logic [7:0] g,
                              output logic [7:0] b);
        logic [7:0] top;
        logic [7:0] other;
        case ($urandom_range(0, 9))
            0: begin
                r = 8'($urandom);
                g = r;
                b = r;
            end
            1: begin
                top   = 8'($urandom_range(1, 255));
                other = 8'($urandom_range(0, top));
                case ($urandom_range(0, 2))
                    0: begin r = top;   g = top;   b = other; end
                    1: begin r = top;   g = other; b = top;   end
                    default: begin r = other; g = top; b = top; end
                endcase
            end
            2: begin
                r = 8'($urandom_range(0, 7));
                g = 8'($urandom_range(0, 7));
                b = 8'($urandom_range(0, 7));
            end
            3: begin
                // near-grey: small spreads make the hue quotient coarse
                r = 8'($urandom);
                g = r ^ 8'($urandom_range(0, 3));
                b = r ^ 8'($urandom_range(0, 3));
            end
            default: begin
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one pixel and hold it until the block takes it. The expected
    // result is queued at the accepting edge.
    task automatic offer_pixel(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic typed,
                               input hsv_t typed_hsv);
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        hsv_due.push_back(typed ? typed_hsv : rgb_to_hsv(r, g, b));
        accepted_items++;
    endtask

    // Drop valid for a number of cycles; zero keeps the item stream back to back.
    task automatic idle_input(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Hold the input off until every owed result has come out. With nothing
    // owed, valid is already low from the last gap and is left alone.
    task automatic wait_drained();
        if (hsv_due.size() != 0) begin
            s_valid <= 1'b0;
            while (hsv_due.size() != 0) @(posedge aclk);
        end
    endtask

    initial begin
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            offer_pixel(directed_rows[i].red, directed_rows[i].green,
                        directed_rows[i].blue, directed_rows[i].typed,
                        directed_rows[i].hsv);
            idle_input(pick_gap());
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == DRAIN_AT) wait_drained();
            draw_pixel(r, g, b);
            offer_pixel(r, g, b, 1'b0, '0);
            // burst window: no input gaps at all
            if (n < BURST_FIRST || n >= BURST_LAST) idle_input(pick_gap());
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && hsv_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: random stalls, one long hold-off to fill the pipeline
    // ------------------------------------------------------------------
    initial begin
        int  stall;
        bit  held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            // occasional long runs with no stalls
            if ($urandom_range(0, 19) == 0) repeat ($urandom_range(50, 150)) @(posedge aclk);
            else repeat ($urandom_range(1, 8)) @(posedge aclk);
            if (!held && accepted_items >= HOLD_AFTER) begin
                // long hold-off while the sender keeps offering; s_ready must drop
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        hsv_t want;
        if (aresetn && m_valid && m_ready) begin
            if (hsv_due.size() == 0) begin
                $error("result with nothing owed: hue %0d saturation %0d brightness %0d",
                       m_hue, m_saturation, m_brightness);
                mismatch_count++;
            end else begin
                want = hsv_due.pop_front();
                if (m_hue !== want.hue) begin
                    $error("hue: expected %0d, got %0d", want.hue, m_hue);
                    mismatch_count++;
                end
                if (m_saturation !== want.saturation) begin
                    $error("saturation: expected %0d, got %0d", want.saturation, m_saturation);
                    mismatch_count++;
                end
                if (m_brightness !== want.brightness) begin
                    $error("brightness: expected %0d, got %0d", want.brightness, m_brightness);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
